// File: src/assert_macros.svh
// Assertion helpers used by the RTL datapath (phbs_dp)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: src/phbs_pkg.sv
package phbs_pkg;

   localparam logic [2:0] MODE_SET   = 3'd0;
   localparam logic [2:0] MODE_ADD   = 3'd1;
   localparam logic [2:0] MODE_GET   = 3'd2;
   localparam logic [2:0] MODE_COUNT = 3'd3;
   localparam logic [2:0] MODE_MEAN  = 3'd4;
   localparam logic [2:0] MODE_VAR   = 3'd5;

   localparam logic REG_AZIMUTH   = 1'b0;
   localparam logic REG_ELEVATION = 1'b1;

   localparam logic [6:0] AZIMUTH_RESET   = 7'd64;
   localparam logic [5:0] ELEVATION_RESET = 6'd32;

   localparam logic [31:0] Q_ONE          = 32'h0001_0000;
   localparam logic [31:0] Q_NINETY_NINE  = 32'h0063_0000;
   localparam logic [31:0] Q_MAX          = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN          = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_ADDR, ST_READ, ST_RMW,
      ST_SCAN, ST_DRAIN, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RES_ZERO, RES_BIN, RES_COUNT, RES_QUO, RES_ONE, RES_NINETY_NINE
   } res_sel_type;

   typedef struct packed {
      logic        clr_step;
      logic        latch;
      logic        mod_step;
      logic        addr_calc;
      logic        rd_issue;
      logic        rmw;
      logic        scan_start;
      logic        scan_step;
      logic        div_start;
      logic        div_step;
      logic        res_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       mod_last;
      logic       scan_last;
      logic       pipe_busy;
      logic       div_last;
      logic       n_zero;
      logic       out_free;
      logic [2:0] mode;
   } sts_type;

endpackage

// File: src/phbs_if.sv
interface phbs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [7:0]  azimuth_index;
   logic signed [6:0]  elevation_index;
   logic signed [31:0] value_in;
   modport source (output valid, mode, azimuth_index, elevation_index, value_in,
                   input ready);
   modport sink (input valid, mode, azimuth_index, elevation_index, value_in,
                 output ready);
endinterface

interface phbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value_out;
   logic               bin_valid;
   logic [11:0]        valid_count;
   modport source (output valid, value_out, bin_valid, valid_count, input ready);
   modport sink (input valid, value_out, bin_valid, valid_count, output ready);
endinterface

// File: src/phbs_ctrl.sv
module phbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_mode,
   output logic              req_ready,
   input  phbs_pkg::sts_type sts,
   output phbs_pkg::cmd_type cmd
);

   phbs_pkg::state_type state_ff, state_in;
   logic                pass2_ff, pass2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phbs_pkg::ST_CLEAR;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass2_in  = pass2_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         phbs_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = phbs_pkg::ST_IDLE;
         end
         phbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            pass2_in  = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (req_mode) inside
                  phbs_pkg::MODE_SET, phbs_pkg::MODE_ADD, phbs_pkg::MODE_GET:
                     state_in = phbs_pkg::ST_MOD;
                  phbs_pkg::MODE_COUNT, phbs_pkg::MODE_MEAN, phbs_pkg::MODE_VAR:
                     state_in = phbs_pkg::ST_SCAN;
                  default: state_in = phbs_pkg::ST_DONE;
               endcase
            end
         end
         phbs_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) state_in = phbs_pkg::ST_ADDR;
         end
         phbs_pkg::ST_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in = phbs_pkg::ST_READ;
         end
         phbs_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in = phbs_pkg::ST_RMW;
         end
         phbs_pkg::ST_RMW: begin
            cmd.rmw = 1'b1;
            state_in = phbs_pkg::ST_DONE;
         end
         phbs_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = phbs_pkg::ST_DRAIN;
         end
         phbs_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               if (sts.mode == phbs_pkg::MODE_COUNT || sts.n_zero) begin
                  state_in = phbs_pkg::ST_DONE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in = phbs_pkg::ST_DIV;
               end
            end
         end
         phbs_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               if (sts.mode == phbs_pkg::MODE_VAR && !pass2_ff) begin
                  // mean is known: second pass for the squared deviations
                  cmd.scan_start = 1'b1;
                  pass2_in = 1'b1;
                  state_in = phbs_pkg::ST_SCAN;
               end else begin
                  state_in = phbs_pkg::ST_DONE;
               end
            end
         end
         phbs_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.res_load = 1'b1;
               case (sts.mode) inside
                  phbs_pkg::MODE_SET, phbs_pkg::MODE_ADD, phbs_pkg::MODE_GET:
                     cmd.res_sel = phbs_pkg::RES_BIN;
                  phbs_pkg::MODE_COUNT: cmd.res_sel = phbs_pkg::RES_COUNT;
                  phbs_pkg::MODE_MEAN:
                     cmd.res_sel = sts.n_zero ? phbs_pkg::RES_ONE : phbs_pkg::RES_QUO;
                  phbs_pkg::MODE_VAR:
                     cmd.res_sel = sts.n_zero ? phbs_pkg::RES_NINETY_NINE
                                              : phbs_pkg::RES_QUO;
                  default: cmd.res_sel = phbs_pkg::RES_ZERO;
               endcase
               state_in = phbs_pkg::ST_IDLE;
            end
         end
         default: state_in = phbs_pkg::ST_CLEAR;
      endcase
   end

endmodule

// File: src/phbs_dp.sv
`include "assert_macros.svh"

module phbs_dp #(
   parameter int AZIMUTH_BINS   = 64,
   parameter int ELEVATION_BINS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  phbs_pkg::cmd_type  cmd,
   output phbs_pkg::sts_type  sts,
   input  logic [6:0]         azimuth_bins_used,
   input  logic [5:0]         elevation_bins_used,
   input  logic [2:0]         req_mode,
   input  logic signed [7:0]  req_azimuth_index,
   input  logic signed [6:0]  req_elevation_index,
   input  logic signed [31:0] req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value_out,
   output logic               rsp_bin_valid,
   output logic [11:0]        rsp_valid_count
);

   localparam int DEPTH = AZIMUTH_BINS * ELEVATION_BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUMW  = 46 + CW;
   localparam int DCW   = $clog2(SUMW);

   // bit 32 is the valid mark
   logic [32:0] mem [DEPTH];
   logic [32:0] q_ff;

   logic [6:0]  weff;
   logic [5:0]  heff;
   logic [12:0] total_ff;

   logic [2:0]         mode_ff;
   logic               neg_ff;
   logic signed [6:0]  elev_ff;
   logic signed [31:0] val_ff;
   logic [7:0]         mod_a_ff;
   logic [6:0]         mod_r_ff;
   logic [2:0]         mod_n_ff;
   logic [AW-1:0]      addr_ff;
   logic [AW-1:0]      scan_ff;

   logic [31:0] bin_val_ff;
   logic        bin_vld_ff;

   logic        p1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic        s2_mark_ff, s2_pos_ff, s3_mark_ff, s3_pos_ff;
   logic [30:0] s2_val_ff, s3_val_ff, s2_absd_ff;
   logic [61:0] s3_prod_ff;
   logic        var_pass_ff;
   logic [30:0] mean_ff;
   logic [CW-1:0]   cnt_ff;
   logic [SUMW-1:0] sum_ff;

   logic [SUMW-1:0] div_q_ff, div_q_in;
   logic [CW-1:0]   div_r_ff, div_r_in;
   logic [DCW-1:0]  div_n_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_bin_valid_ff;
   logic [11:0] rsp_count_ff;

   // effective grid size
   always_comb begin
      if (azimuth_bins_used == 7'd0) weff = 7'd1;
      else if ({2'b00, azimuth_bins_used} > 9'(AZIMUTH_BINS)) weff = 7'(AZIMUTH_BINS);
      else weff = azimuth_bins_used;
      if (elevation_bins_used == 6'd0) heff = 6'd1;
      else if ({2'b00, elevation_bins_used} > 8'(ELEVATION_BINS))
         heff = 6'(ELEVATION_BINS);
      else heff = elevation_bins_used;
   end

   always_ff @(posedge clock) total_ff <= 13'(weff) * 13'(heff);

   // azimuth remainder: one restoring step per cycle
   logic [7:0] mod_t;
   logic [6:0] mod_r_in;
   always_comb begin
      mod_t = {mod_r_ff, mod_a_ff[7]};
      if (mod_t >= {1'b0, weff}) mod_r_in = 7'(mod_t - {1'b0, weff});
      else mod_r_in = mod_t[6:0];
   end

   logic [6:0]  az;
   logic [5:0]  el;
   logic [7:0]  refl;
   logic [13:0] addr_calc;
   always_comb begin
      az = (neg_ff && mod_r_ff != 7'd0) ? weff - mod_r_ff : mod_r_ff;
      refl = {1'b0, heff, 1'b0} - 8'd1 - {2'b00, elev_ff[5:0]};
      if (elev_ff[6]) el = 6'd0;
      else if (elev_ff[5:0] >= heff) el = refl[7] ? 6'd0 : refl[5:0];
      else el = elev_ff[5:0];
      addr_calc = 14'(el) * 14'(weff) + 14'(az);
   end

   // item registers and address unit
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= req_mode;
         neg_ff   <= req_azimuth_index[7];
         elev_ff  <= req_elevation_index;
         val_ff   <= req_value_in;
         mod_a_ff <= req_azimuth_index[7] ? 8'(-req_azimuth_index) : req_azimuth_index;
         mod_r_ff <= 7'd0;
         mod_n_ff <= 3'd0;
      end else if (cmd.mod_step) begin
         mod_a_ff <= {mod_a_ff[6:0], 1'b0};
         mod_r_ff <= mod_r_in;
         mod_n_ff <= mod_n_ff + 3'd1;
      end
      if (cmd.addr_calc) addr_ff <= AW'(addr_calc);
   end

   // read-modify-write of one bin
   logic [31:0] old_v;
   logic [32:0] add_s;
   logic [31:0] new_v;
   always_comb begin
      old_v = q_ff[32] ? q_ff[31:0] : 32'd0;
      add_s = {old_v[31], old_v} + {val_ff[31], val_ff};
      if (add_s[32] != add_s[31]) new_v = add_s[32] ? phbs_pkg::Q_MIN : phbs_pkg::Q_MAX;
      else new_v = add_s[31:0];
      if (mode_ff == phbs_pkg::MODE_SET) new_v = val_ff;
   end

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [32:0]   mem_wd;
   always_comb begin
      mem_we = cmd.clr_step || (cmd.rmw && mode_ff != phbs_pkg::MODE_GET);
      mem_wa = cmd.clr_step ? scan_ff : addr_ff;
      mem_wd = cmd.clr_step ? 33'd0 : {1'b1, new_v};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      q_ff <= mem[cmd.rd_issue ? addr_ff : scan_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.rmw) begin
         if (mode_ff == phbs_pkg::MODE_GET) begin
            bin_val_ff <= old_v;
            bin_vld_ff <= q_ff[32];
         end else begin
            bin_val_ff <= new_v;
            bin_vld_ff <= 1'b1;
         end
      end
   end

   // scan address: clearing sweep after reset, then the statistics passes
   always_ff @(posedge clock) begin
      if (reset) scan_ff <= '0;
      else if (cmd.latch || cmd.scan_start) scan_ff <= '0;
      else if (cmd.clr_step || cmd.scan_step) scan_ff <= scan_ff + AW'(1);
   end

   // scan pipeline: read, qualify, square, accumulate
   logic        s1_pos;
   logic [31:0] s1_diff;
   always_comb begin
      s1_pos  = q_ff[32] && !q_ff[31] && q_ff[30:0] != 31'd0;
      s1_diff = {1'b0, mean_ff} - {1'b0, q_ff[30:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= cmd.scan_step;
         s2_vld_ff <= p1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      s2_mark_ff <= q_ff[32];
      s2_pos_ff  <= s1_pos;
      s2_val_ff  <= q_ff[30:0];
      s2_absd_ff <= s1_diff[31] ? 31'(-s1_diff) : s1_diff[30:0];
      s3_mark_ff <= s2_mark_ff;
      s3_pos_ff  <= s2_pos_ff;
      s3_val_ff  <= s2_val_ff;
      s3_prod_ff <= s2_absd_ff * s2_absd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) var_pass_ff <= 1'b0;
      else if (cmd.scan_start) var_pass_ff <= 1'b1;
      if (cmd.scan_start) mean_ff <= div_q_in[30:0];
      if (cmd.latch || cmd.scan_start) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (s3_vld_ff) begin
         if (mode_ff == phbs_pkg::MODE_COUNT) cnt_ff <= cnt_ff + CW'(s3_mark_ff);
         else cnt_ff <= cnt_ff + CW'(s3_pos_ff);
         if (s3_pos_ff)
            sum_ff <= sum_ff + (var_pass_ff ? SUMW'(s3_prod_ff[61:16]) : SUMW'(s3_val_ff));
      end
   end

   // sum / count, one quotient bit per cycle
   logic [CW:0] div_t;
   always_comb begin
      div_t = {div_r_ff, div_q_ff[SUMW-1]};
      if (div_t >= {1'b0, cnt_ff}) begin
         div_r_in = CW'(div_t - {1'b0, cnt_ff});
         div_q_in = {div_q_ff[SUMW-2:0], 1'b1};
      end else begin
         div_r_in = div_t[CW-1:0];
         div_q_in = {div_q_ff[SUMW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff <= sum_ff;
         div_r_ff <= '0;
         div_n_ff <= '0;
      end else if (cmd.div_step) begin
         div_q_ff <= div_q_in;
         div_r_ff <= div_r_in;
         div_n_ff <= div_n_ff + DCW'(1);
      end
   end

   logic [31:0] quo_sat;
   assign quo_sat = (|div_q_ff[SUMW-1:31]) ? phbs_pkg::Q_MAX : div_q_ff[31:0];

   // output word register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.res_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.res_load) begin
         case (cmd.res_sel)
            phbs_pkg::RES_BIN: begin
               rsp_value_ff     <= bin_val_ff;
               rsp_bin_valid_ff <= bin_vld_ff;
               rsp_count_ff     <= 12'd0;
            end
            phbs_pkg::RES_COUNT: begin
               rsp_value_ff     <= 32'd0;
               rsp_bin_valid_ff <= 1'b0;
               rsp_count_ff     <= 12'(cnt_ff);
            end
            phbs_pkg::RES_QUO: begin
               rsp_value_ff     <= quo_sat;
               rsp_bin_valid_ff <= 1'b0;
               rsp_count_ff     <= 12'd0;
            end
            phbs_pkg::RES_ONE: begin
               rsp_value_ff     <= phbs_pkg::Q_ONE;
               rsp_bin_valid_ff <= 1'b0;
               rsp_count_ff     <= 12'd0;
            end
            phbs_pkg::RES_NINETY_NINE: begin
               rsp_value_ff     <= phbs_pkg::Q_NINETY_NINE;
               rsp_bin_valid_ff <= 1'b0;
               rsp_count_ff     <= 12'd0;
            end
            default: begin
               rsp_value_ff     <= 32'd0;
               rsp_bin_valid_ff <= 1'b0;
               rsp_count_ff     <= 12'd0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_bin_valid   = rsp_bin_valid_ff;
   assign rsp_valid_count = rsp_count_ff;

   always_comb begin
      sts.clr_last  = scan_ff == AW'(DEPTH - 1);
      sts.mod_last  = mod_n_ff == 3'd7;
      sts.scan_last = 14'(scan_ff) == 14'(total_ff) - 14'd1;
      sts.pipe_busy = p1_vld_ff || s2_vld_ff || s3_vld_ff;
      sts.div_last  = div_n_ff == DCW'(SUMW - 1);
      sts.n_zero    = cnt_ff == '0;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.mode      = mode_ff;
   end

   `ASSERT_CLK(a_no_overwrite, clock, reset, cmd.res_load |-> sts.out_free, "pending word overwritten")
   `ASSERT_CLK(a_div_settled, clock, reset, cmd.div_start |-> !sts.pipe_busy, "divide before scan drained")
   `ASSERT_CLK(a_read_then_rmw, clock, reset, cmd.rd_issue |=> cmd.rmw, "bin read not followed by update")

endmodule

// File: src/polar_histogram_bin_store.sv
// Bin operations (set, add, get): azimuth remainder, address, read, update, result word.
// Count and mean: one pass over the W*H bins in use plus a drain of the scan pipeline;
// mean adds a divide if any bin is positive. Variance, if so, runs two passes
// and two divides. One item at a time; the next is taken while a word waits.
// Reset (synchronous) clears every valid mark with a sweep over all
// AZIMUTH_BINS*ELEVATION_BINS bins, during which no item is taken.
module polar_histogram_bin_store #(
   parameter int AZIMUTH_BINS   = 64,
   parameter int ELEVATION_BINS = 32
) (
   input  logic         clock,
   input  logic         reset,
   phbs_req_if.sink     req_chan,
   phbs_rsp_if.source   rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [6:0] azimuth_bins_used_ff;
   logic [5:0] elevation_bins_used_ff;
   phbs_pkg::cmd_type cmd;
   phbs_pkg::sts_type sts;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         azimuth_bins_used_ff   <= phbs_pkg::AZIMUTH_RESET;
         elevation_bins_used_ff <= phbs_pkg::ELEVATION_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            phbs_pkg::REG_AZIMUTH:   azimuth_bins_used_ff   <= pwdata[6:0];
            phbs_pkg::REG_ELEVATION: elevation_bins_used_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         phbs_pkg::REG_AZIMUTH:   prdata = {25'd0, azimuth_bins_used_ff};
         phbs_pkg::REG_ELEVATION: prdata = {26'd0, elevation_bins_used_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   phbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   phbs_dp #(
      .AZIMUTH_BINS   (AZIMUTH_BINS),
      .ELEVATION_BINS (ELEVATION_BINS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .azimuth_bins_used   (azimuth_bins_used_ff),
      .elevation_bins_used (elevation_bins_used_ff),
      .req_mode            (req_chan.mode),
      .req_azimuth_index   (req_chan.azimuth_index),
      .req_elevation_index (req_chan.elevation_index),
      .req_value_in        (req_chan.value_in),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_value_out       (rsp_chan.value_out),
      .rsp_bin_valid       (rsp_chan.bin_valid),
      .rsp_valid_count     (rsp_chan.valid_count)
   );

endmodule

// File: sim/polar_histogram_bin_store_tb.sv
`timescale 1ns / 1ps

module polar_histogram_bin_store_tb;

   localparam int AZ_MAX = 64;
   localparam int EL_MAX = 32;
   localparam int DEPTH  = AZ_MAX * EL_MAX;

   // spare mode codes, no operation
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]         mode;
      logic signed [7:0]  azimuth;
      logic signed [6:0]  elevation;
      logic signed [31:0] value;
   } bin_op_type;

   typedef struct {
      logic signed [31:0] value;
      logic               bin_valid;
      logic [11:0]        count;
   } bin_word_type;

   class histogram_scoreboard_type;
      logic signed [31:0] bin_value[DEPTH];
      bit                 bin_mark[DEPTH];
      logic [6:0]         azimuth_reg;
      logic [5:0]         elevation_reg;
      bin_word_type       expected_words[$];
      int                 errors;

      function new();
         azimuth_reg   = phbs_pkg::AZIMUTH_RESET;
         elevation_reg = phbs_pkg::ELEVATION_RESET;
         foreach (bin_mark[k]) begin
            bin_mark[k]  = 0;
            bin_value[k] = '0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         if (idx == phbs_pkg::REG_AZIMUTH) azimuth_reg = data[6:0];
         else elevation_reg = data[5:0];
      endfunction

      function int width_used();
         return azimuth_reg < 1 ? 1 : (azimuth_reg > AZ_MAX ? AZ_MAX : int'(azimuth_reg));
      endfunction

      function int height_used();
         return elevation_reg < 1 ? 1 :
                (elevation_reg > EL_MAX ? EL_MAX : int'(elevation_reg));
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // sum and number of marked bins holding a positive value
      function void positive_sum(output longint sum, output int n);
         int total;
         total = width_used() * height_used();
         sum = 0;
         n = 0;
         for (int k = 0; k < total; k++)
            if (bin_mark[k] && bin_value[k] > 0) begin
               sum += bin_value[k];
               n++;
            end
      endfunction

      function void note_op(bin_op_type op);
         bin_word_type w;
         int wd, ht, az, el, addr, n, total;
         longint s;
         longint d;
         longint unsigned a, acc, q;
         logic signed [31:0] m;
         wd = width_used();
         ht = height_used();
         az = ((int'(op.azimuth) % wd) + wd) % wd;
         if (op.elevation < 0) el = 0;
         else if (int'(op.elevation) > ht - 1) begin
            el = 2 * ht - 1 - int'(op.elevation);
            if (el < 0) el = 0;
         end else el = int'(op.elevation);
         addr = el * wd + az;
         w.value = '0;
         w.bin_valid = 0;
         w.count = '0;
         case (op.mode)
            phbs_pkg::MODE_SET: begin
               bin_value[addr] = op.value;
               bin_mark[addr] = 1;
               w.value = op.value;
               w.bin_valid = 1;
            end
            phbs_pkg::MODE_ADD: begin
               s = (bin_mark[addr] ? longint'(bin_value[addr]) : 0) + longint'(op.value);
               if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
               if (s < -64'sh8000_0000) s = -64'sh8000_0000;
               bin_value[addr] = s[31:0];
               bin_mark[addr] = 1;
               w.value = s[31:0];
               w.bin_valid = 1;
            end
            phbs_pkg::MODE_GET: begin
               w.bin_valid = bin_mark[addr];
               w.value = bin_mark[addr] ? bin_value[addr] : '0;
            end
            phbs_pkg::MODE_COUNT: begin
               total = wd * ht;
               for (int k = 0; k < total; k++) w.count += bin_mark[k];
            end
            phbs_pkg::MODE_MEAN: begin
               positive_sum(s, n);
               w.value = (n == 0) ? phbs_pkg::Q_ONE : 32'(s / n);
            end
            phbs_pkg::MODE_VAR: begin
               positive_sum(s, n);
               if (n == 0) w.value = phbs_pkg::Q_NINETY_NINE;
               else begin
                  m = 32'(s / n);
                  acc = 0;
                  total = wd * ht;
                  for (int k = 0; k < total; k++)
                     if (bin_mark[k] && bin_value[k] > 0) begin
                        d = longint'(m) - longint'(bin_value[k]);
                        a = d < 0 ? -d : d;
                        acc += (a * a) >> 16;
                     end
                  q = acc / n;
                  w.value = q > 64'h7FFF_FFFF ? phbs_pkg::Q_MAX : q[31:0];
               end
            end
            default: ;
         endcase
         expected_words.insert(expected_words.size(), w);
      endfunction

      function void check_word(bin_word_type got);
         bin_word_type e;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: value_out %h", got.value);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (got.value !== e.value) begin
            $error("value_out: expected %h, got %h", e.value, got.value);
            errors++;
         end
         if (got.bin_valid !== e.bin_valid) begin
            $error("bin_valid: expected %b, got %b", e.bin_valid, got.bin_valid);
            errors++;
         end
         if (got.count !== e.count) begin
            $error("valid_count: expected %0d, got %0d", e.count, got.count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   phbs_req_if req_chan();
   phbs_rsp_if rsp_chan();

   histogram_scoreboard_type sb;
   bit quiet_rx;
   bit long_hold_req;

   polar_histogram_bin_store i_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("polar_histogram_bin_store_tb: FAIL");
      $finish;
   end

   // result side: random back-pressure, plus one long hold on request
   initial begin
      int hold;
      bin_word_type got;
      hold = 0;
      rsp_chan.ready <= 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.value = rsp_chan.value_out;
            got.bin_valid = rsp_chan.bin_valid;
            got.count = rsp_chan.valid_count;
            sb.check_word(got);
         end
         if (long_hold_req) begin
            long_hold_req = 0;
            hold = 400;
         end else if (!quiet_rx && hold == 0 && $urandom_range(0, 99) == 0)
            hold = $urandom_range(20, 80);
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 0;
         end else
            rsp_chan.ready <= quiet_rx || ($urandom_range(0, 99) >= 25);
      end
   end

   task automatic csr_write(logic idx, logic [31:0] data);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.write_reg(idx, data);
   endtask

   // caller sits on a clock edge; returns on the edge at which the word went in
   task automatic send_op(bin_op_type op);
      req_chan.valid <= 1;
      req_chan.mode <= op.mode;
      req_chan.azimuth_index <= op.azimuth;
      req_chan.elevation_index <= op.elevation;
      req_chan.value_in <= op.value;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_op(op);
   endtask

   task automatic idle_gap(bit quiet);
      int g;
      g = 0;
      if (!quiet) begin
         if ($urandom_range(0, 99) < 3) g = $urandom_range(20, 60);
         else if ($urandom_range(0, 99) < 30) g = $urandom_range(1, 3);
      end
      if (g > 0) begin
         req_chan.valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return phbs_pkg::Q_MAX;
         1: return phbs_pkg::Q_MIN;
         2: return '0;
         3: return $urandom_range(0, 200000);
         4: return -$urandom_range(0, 200000);
         5: return phbs_pkg::Q_MAX - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic bin_op_type random_op(int stat_pct);
      bin_op_type op;
      int r;
      r = $urandom_range(0, 999);
      if (r < stat_pct * 10)
         op.mode = 3'($urandom_range(phbs_pkg::MODE_COUNT, phbs_pkg::MODE_VAR));
      else if (r > 992) op.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else op.mode = 3'($urandom_range(phbs_pkg::MODE_SET, phbs_pkg::MODE_GET));
      op.azimuth = 8'($urandom);
      if ($urandom_range(0, 1)) op.elevation = 7'($urandom_range(0, sb.height_used() - 1));
      else op.elevation = 7'($urandom);
      op.value = pick_value();
      return op;
   endfunction

   function automatic bin_op_type mk(logic [2:0] m, int az, int el, logic signed [31:0] v);
      bin_op_type op;
      op.mode = m;
      op.azimuth = 8'(az);
      op.elevation = 7'(el);
      op.value = v;
      return op;
   endfunction

   initial begin
      int wcfg[8];
      int hcfg[8];
      int per_phase, stat_pct;
      bin_op_type directed[$];
      wcfg = '{1, 64, 0, 127, 5, 7, 1, 64};
      hcfg = '{1, 32, 0, 63, 3, 1, 32, 2};
      sb = new();
      reset <= 1;
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      paddr <= '0;
      pwdata <= '0;
      req_chan.valid <= 0;
      req_chan.mode <= phbs_pkg::MODE_SET;
      req_chan.azimuth_index <= '0;
      req_chan.elevation_index <= '0;
      req_chan.value_in <= '0;
      quiet_rx = 0;
      long_hold_req = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty: default mean/var, zero count, unwritten get, then edge cases
      directed = '{
         mk(phbs_pkg::MODE_MEAN, 0, 0, 0), mk(phbs_pkg::MODE_VAR, 0, 0, 0),
         mk(phbs_pkg::MODE_COUNT, 0, 0, 0),
         mk(phbs_pkg::MODE_GET, 3, 3, 0),
         mk(phbs_pkg::MODE_SET, 0, 0, phbs_pkg::Q_MAX), mk(phbs_pkg::MODE_ADD, 0, 0, 1),
         mk(phbs_pkg::MODE_SET, 1, 0, phbs_pkg::Q_MIN), mk(phbs_pkg::MODE_ADD, 1, 0, -1),
         mk(phbs_pkg::MODE_ADD, 2, 0, 32'sh0001_8000), mk(phbs_pkg::MODE_GET, 2, 0, 0),
         mk(phbs_pkg::MODE_SET, -128, -64, 32'sh0003_0000), mk(phbs_pkg::MODE_GET, 0, 0, 0),
         mk(phbs_pkg::MODE_SET, 127, 63, 32'sh0000_4000), mk(phbs_pkg::MODE_GET, 63, 0, 0),
         mk(phbs_pkg::MODE_SET, -1, 40, 32'sh0010_0000), mk(phbs_pkg::MODE_GET, 63, 23, 0),
         mk(phbs_pkg::MODE_SET, 64, 31, 32'sh7000_0000), mk(phbs_pkg::MODE_GET, 0, 31, 0),
         mk(MODE_SPARE_LO, 5, 5, 7), mk(MODE_SPARE_HI, 5, 5, 7),
         mk(phbs_pkg::MODE_COUNT, 0, 0, 0), mk(phbs_pkg::MODE_MEAN, 0, 0, 0),
         mk(phbs_pkg::MODE_VAR, 0, 0, 0)
      };
      foreach (directed[k]) begin
         send_op(directed[k]);
         idle_gap(0);
      end
      drain();

      foreach (wcfg[p]) begin
         csr_write(phbs_pkg::REG_AZIMUTH, 32'(wcfg[p]));
         csr_write(phbs_pkg::REG_ELEVATION, 32'(hcfg[p]));
         @(posedge clock);
         per_phase = 120;
         stat_pct = (sb.width_used() * sb.height_used() > 256) ? 2 : 8;
         quiet_rx = (p == 4);
         if (p == 2) begin
            // long receiver hold while items keep coming
            long_hold_req = 1;
            for (int k = 0; k < 30; k++) send_op(random_op(0));
         end
         if (p == 5) begin
            // a reflected row that falls below zero
            send_op(mk(phbs_pkg::MODE_SET, 2, 5, 32'sh0000_0100));
            send_op(mk(phbs_pkg::MODE_GET, 2, 0, 0));
         end
         for (int k = 0; k < per_phase; k++) begin
            send_op(random_op(stat_pct));
            idle_gap(p == 4);
            if (k == per_phase / 2 && p == 1) drain();
         end
         drain();
      end
      quiet_rx = 0;

      if (sb.errors == 0 && sb.pending() == 0)
         $display("polar_histogram_bin_store_tb: PASS");
      else
         $display("polar_histogram_bin_store_tb: FAIL");
      $finish;
   end

endmodule
